/* sv/dtq_pkg.sv */
`timescale 1ns / 1ps
// Package for the deadline timer queue: sizes, request and result codes,
// payload words and the command/status structs between controller and datapath.
// Depends on nothing.
package dtq_pkg;

   localparam int CAPACITY    = 64;
   localparam int TIME_BITS   = 48;
   localparam int HANDLE_BITS = 16;
   localparam int IDX_W       = (CAPACITY < 2) ? 1 : $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_CLEAR  = 2'd1;
   localparam logic [1:0] REQ_CHECK  = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [2:0] KIND_FIRED    = 3'd0;
   localparam logic [2:0] KIND_ADDED    = 3'd1;
   localparam logic [2:0] KIND_REJECTED = 3'd2;
   localparam logic [2:0] KIND_CLEARED  = 3'd3;
   localparam logic [2:0] KIND_NONE_DUE = 3'd4;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [TIME_BITS-1:0]   deadline;
      logic [HANDLE_BITS-1:0] routine_id;
      logic [TIME_BITS-1:0]   now;
   } req_word_type;

   typedef struct packed {
      logic [2:0]             kind;
      logic [HANDLE_BITS-1:0] fired_routine;
      logic [TIME_BITS-1:0]   fired_deadline;
      logic                   timer_armed;
      logic [TIME_BITS-1:0]   timer_delay;
      logic                   last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      RD_POS_M1,
      RD_POS,
      RD_N,
      RD_K
   } rd_sel_type;

   typedef struct packed {
      logic       latch;
      rd_sel_type rd_sel;
      logic       pos_load_count;
      logic       pos_clear;
      logic       pos_inc;
      logic       shift_write;
      logic       new_write;
      logic       count_clear;
      logic       n_from_pos;
      logic       status_load;
      logic       emit_single;
      logic [2:0] emit_kind;
      logic       emit_pop;
      logic       commit_pop;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       full;
      logic       pos_zero;
      logic       pos_at_count;
      logic       rd_gt_dl;
      logic       rd_due;
      logic       k_last;
   } dp_status_type;

endpackage

/* sv/deadline_timer_queue.sv */
`timescale 1ns / 1ps
// Top level of the deadline timer queue: controller plus datapath.
// Depends on dtq_pkg, dtq_control and dtq_datapath.
//
// A request word is taken when start is high and busy is low; results leave
// one word per cycle on rsp with rsp_strobe and cannot be held off. A clear
// or a rejected add gives one result; an accepted add first moves each stored
// entry with a later deadline up one place until a stored entry that is not
// later (or the front) ends the search, and a check scans due entries until a
// not-due entry (or the end) ends the scan and then gives one result per
// fired entry, or a single none-due result. Busy drops in the cycle of the
// last result, so the next request can be taken at the edge that ends it.
// The sequencing is set by the single read port of the entry memory, whose
// registered read comes ahead of each compare.
module deadline_timer_queue import dtq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req,
   output logic         rsp_strobe,
   output rsp_word_type rsp
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          take;

   assign take = start & ~busy;

   dtq_control u_control (
      .clock  (clock),
      .reset  (reset),
      .start  (take),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   dtq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

endmodule

/* sv/dtq_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the deadline timer queue: circular entry memory, pointers,
// counters, timer status and the result register.
// Depends on dtq_pkg.
module dtq_datapath import dtq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  req_word_type  req,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_strobe,
   output rsp_word_type  rsp
);

   logic [TIME_BITS-1:0]   dl_mem [CAPACITY];
   logic [HANDLE_BITS-1:0] hd_mem [CAPACITY];

   req_word_type           req_ff;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [CNT_W-1:0]       k_ff, k_in;
   logic [TIME_BITS-1:0]   rd_dl_ff;
   logic [HANDLE_BITS-1:0] rd_hd_ff;
   logic                   arm_ff;
   logic [TIME_BITS-1:0]   delay_ff;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type           rsp_ff, rsp_in;

   logic [CNT_W-1:0]       rd_rel;
   logic [IDX_W-1:0]       rd_addr, wr_addr;
   logic                   wr_en;
   logic [TIME_BITS-1:0]   wr_dl;
   logic [HANDLE_BITS-1:0] wr_hd;

   // Relative positions are offsets from the head; one subtract folds the sum.
   function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] h,
                                             input logic [CNT_W-1:0] rel);
      logic [CNT_W+1:0] sum;
      sum = {{(CNT_W + 2 - IDX_W){1'b0}}, h} + {2'b00, rel};
      if (sum >= (CNT_W + 2)'(CAPACITY)) sum = sum - (CNT_W + 2)'(CAPACITY);
      return sum[IDX_W-1:0];
   endfunction

   always_comb begin
      case (cmd.rd_sel)
         RD_POS_M1: rd_rel = pos_ff - CNT_W'(1);
         RD_POS:    rd_rel = pos_ff;
         RD_N:      rd_rel = n_ff;
         // The pop read follows k as it advances, so the next entry is ready.
         RD_K:      rd_rel = k_in;
         default:   rd_rel = pos_ff;
      endcase
      rd_addr = wrap(head_ff, rd_rel);
      wr_addr = wrap(head_ff, pos_ff);
      wr_en   = cmd.shift_write | cmd.new_write;
      wr_dl   = cmd.new_write ? req_ff.deadline : rd_dl_ff;
      wr_hd   = cmd.new_write ? req_ff.routine_id : rd_hd_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dl_mem[wr_addr] <= wr_dl;
         hd_mem[wr_addr] <= wr_hd;
      end
      rd_dl_ff <= dl_mem[rd_addr];
      rd_hd_ff <= hd_mem[rd_addr];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      if (cmd.latch) begin
         n_in = '0;
         k_in = '0;
      end
      if (cmd.pos_load_count) pos_in = count_ff;
      if (cmd.pos_clear) pos_in = '0;
      if (cmd.pos_inc) pos_in = pos_ff + CNT_W'(1);
      if (cmd.shift_write) pos_in = pos_ff - CNT_W'(1);
      if (cmd.new_write) count_in = count_ff + CNT_W'(1);
      if (cmd.count_clear) count_in = '0;
      if (cmd.n_from_pos) n_in = pos_ff;
      if (cmd.emit_pop) k_in = k_ff + CNT_W'(1);
      if (cmd.commit_pop) begin
         head_in  = wrap(head_ff, n_ff);
         count_in = count_ff - n_ff;
      end
   end

   always_comb begin
      rsp_strobe_in = cmd.emit_single | cmd.emit_pop;
      rsp_in        = rsp_ff;
      rsp_in.timer_armed = arm_ff;
      rsp_in.timer_delay = delay_ff;
      if (cmd.emit_pop) begin
         rsp_in.kind           = KIND_FIRED;
         rsp_in.fired_routine  = rd_hd_ff;
         rsp_in.fired_deadline = rd_dl_ff;
         rsp_in.last           = (k_ff + CNT_W'(1) == n_ff);
      end else begin
         rsp_in.kind           = cmd.emit_kind;
         rsp_in.fired_routine  = '0;
         rsp_in.fired_deadline = '0;
         rsp_in.last           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         pos_ff        <= '0;
         n_ff          <= '0;
         k_ff          <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         n_ff          <= n_in;
         k_ff          <= k_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      if (cmd.latch) req_ff <= req;
      // The status read is at the first entry left after any pops.
      if (cmd.status_load) begin
         arm_ff   <= (count_ff > n_ff);
         delay_ff <= ((count_ff > n_ff) && (rd_dl_ff > req_ff.now)) ?
                     (rd_dl_ff - req_ff.now) : '0;
      end
      if (rsp_strobe_in) rsp_ff <= rsp_in;
   end

   always_comb begin
      status.req_type     = req_ff.req_type;
      status.full         = (count_ff >= CNT_W'(CAPACITY));
      status.pos_zero     = (pos_ff == '0);
      status.pos_at_count = (pos_ff == count_ff);
      status.rd_gt_dl     = (rd_dl_ff > req_ff.deadline);
      status.rd_due       = (rd_dl_ff <= req_ff.now);
      status.k_last       = (k_ff + CNT_W'(1) == n_ff);
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

/* sv/dtq_control.sv */
`timescale 1ns / 1ps
// Controller of the deadline timer queue: sequences insert, clear, scan,
// status read and result emission.
// Depends on dtq_pkg.
module dtq_control import dtq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_ADD_TEST,
      S_ADD_CMP,
      S_ADD_WR,
      S_SCAN_TEST,
      S_SCAN_CMP,
      S_SCAN_END,
      S_STAT_RD,
      S_STAT_WAIT,
      S_EMIT,
      S_POP_RD,
      S_POP_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] kind_ff, kind_in;
   logic       busy_ff;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.rd_sel    = RD_POS;
      cmd.emit_kind = kind_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.req_type)
               REQ_ADD: begin
                  if (status.full) begin
                     kind_in  = KIND_REJECTED;
                     state_in = S_STAT_RD;
                  end else begin
                     cmd.pos_load_count = 1'b1;
                     state_in = S_ADD_TEST;
                  end
               end
               REQ_CLEAR: begin
                  cmd.count_clear = 1'b1;
                  kind_in  = KIND_CLEARED;
                  state_in = S_STAT_RD;
               end
               REQ_CHECK: begin
                  cmd.pos_clear = 1'b1;
                  state_in = S_SCAN_TEST;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_ADD_TEST: begin
            cmd.rd_sel = RD_POS_M1;
            state_in = status.pos_zero ? S_ADD_WR : S_ADD_CMP;
         end
         S_ADD_CMP: begin
            // Later entries move up one place until one is not later.
            if (status.rd_gt_dl) begin
               cmd.shift_write = 1'b1;
               state_in = S_ADD_TEST;
            end else begin
               state_in = S_ADD_WR;
            end
         end
         S_ADD_WR: begin
            cmd.new_write = 1'b1;
            kind_in  = KIND_ADDED;
            state_in = S_STAT_RD;
         end
         S_SCAN_TEST: begin
            cmd.rd_sel = RD_POS;
            state_in = status.pos_at_count ? S_SCAN_END : S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (status.rd_due) begin
               cmd.pos_inc = 1'b1;
               state_in = S_SCAN_TEST;
            end else begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            cmd.n_from_pos = 1'b1;
            kind_in  = status.pos_zero ? KIND_NONE_DUE : KIND_FIRED;
            state_in = S_STAT_RD;
         end
         S_STAT_RD: begin
            cmd.rd_sel = RD_N;
            state_in = S_STAT_WAIT;
         end
         S_STAT_WAIT: begin
            cmd.status_load = 1'b1;
            state_in = (kind_ff == KIND_FIRED) ? S_POP_RD : S_EMIT;
         end
         S_EMIT: begin
            cmd.emit_single = 1'b1;
            state_in = S_IDLE;
         end
         S_POP_RD: begin
            cmd.rd_sel = RD_K;
            state_in = S_POP_OUT;
         end
         S_POP_OUT: begin
            // The read for the next entry goes out while this one is emitted.
            cmd.emit_pop = 1'b1;
            cmd.rd_sel   = RD_K;
            if (status.k_last) begin
               cmd.commit_pop = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_POP_OUT) begin
         // k advances this cycle, so address the entry after it.
         cmd.rd_sel = RD_K;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_NONE_DUE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

/* sv/dtq_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the deadline timer queue, bound to the top level.
// Depends on dtq_pkg.
module dtq_props import dtq_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_strobe,
   input rsp_word_type rsp
);

   // A fired word that is not the last is followed at once by the next one.
   a_pop_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp.last |=> rsp_strobe)
      else $error("pop burst broken");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.kind != KIND_FIRED |-> rsp.last)
      else $error("single result not marked last");

   a_idle_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp.timer_armed |-> rsp.timer_delay == '0)
      else $error("delay set while timer disarmed");

   // No request is answered in the cycle right after it is taken.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_strobe)
      else $error("result too early");

endmodule

bind deadline_timer_queue dtq_props u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp        (rsp)
);
